// ===== sv/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper: request and result
// payloads, the job passed from parser to encoder, kind and error codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd1;
    localparam logic [3:0] ERR_RAW_CTRL     = 4'd2;
    localparam logic [3:0] ERR_ESC_CUT      = 4'd3;
    localparam logic [3:0] ERR_BAD_ESC      = 4'd4;
    localparam logic [3:0] ERR_HEX_CUT      = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd6;
    localparam logic [3:0] ERR_HIGH_ALONE   = 4'd7;
    localparam logic [3:0] ERR_HIGH_NO_LOW  = 4'd8;
    localparam logic [3:0] ERR_LONE_LOW     = 4'd9;
    localparam logic [3:0] ERR_NUL          = 4'd10;

    // Input request: one code point of the string body
    typedef struct packed {
        logic [20:0] char_code;
        logic        text_end;
    } in_t;

    // Result: one UTF-8 byte, a close mark or an error
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [3:0] error_code;
        logic       last;
    } out_t;

    // Job from parser to encoder: a code point, a close or an error
    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] cp;
        logic [3:0]  err;
    } job_t;

endpackage

// ===== sv/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Parser: takes one code point per cycle when take is high, tracks escape and
// \uXXXX phases, joins surrogate pairs and hands one job per finished character,
// close or error to the job queue.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  jsu_pkg::in_t     item,
    output logic             job_valid,
    output jsu_pkg::job_t    job
);
    import jsu_pkg::*;

    typedef enum logic [5:0] {
        PH_PLAIN   = 6'b000001,
        PH_ESC     = 6'b000010,
        PH_HEX1    = 6'b000100,
        PH_WANT_BS = 6'b001000,
        PH_WANT_U  = 6'b010000,
        PH_HEX2    = 6'b100000
    } phase_t;

    localparam logic [20:0] CH_QUOTE = 21'h22;
    localparam logic [20:0] CH_BSL   = 21'h5C;
    localparam logic [20:0] CH_SLASH = 21'h2F;
    localparam logic [20:0] CH_B     = 21'h62;
    localparam logic [20:0] CH_F     = 21'h66;
    localparam logic [20:0] CH_N     = 21'h6E;
    localparam logic [20:0] CH_R     = 21'h72;
    localparam logic [20:0] CH_T     = 21'h74;
    localparam logic [20:0] CH_U     = 21'h75;

    phase_t      phase_reg, phase_next;
    logic [11:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  high_reg, high_next;

    logic [20:0] c;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] u;
    logic        restart;

    assign c = item.char_code;
    assign u = {acc_reg, hex_d};

    // Decode one hex digit
    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (c inside {[21'h30:21'h39]})
            hex_d = c[3:0];
        else if (c inside {[21'h61:21'h66], [21'h41:21'h46]})
            hex_d = c[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    // Classify the request and advance the phase
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        high_next  = high_reg;
        restart    = 1'b0;
        job_valid  = 1'b0;
        job.kind   = KIND_DATA;
        job.cp     = c;
        job.err    = ERR_NONE;

        case (phase_reg)
            PH_PLAIN:
            begin
                if (item.text_end)
                begin
                    job_valid = 1'b1; job.kind = KIND_ERROR; job.err = ERR_UNTERMINATED;
                    restart = 1'b1;
                end
                else if (c == CH_QUOTE)
                begin
                    job_valid = 1'b1; job.kind = KIND_CLOSE;
                    restart = 1'b1;
                end
                else if (c < 21'h20)
                begin
                    job_valid = 1'b1; job.kind = KIND_ERROR; job.err = ERR_RAW_CTRL;
                    restart = 1'b1;
                end
                else if (c == CH_BSL)
                    phase_next = PH_ESC;
                else
                    job_valid = 1'b1;
            end
            PH_ESC:
            begin
                phase_next = PH_PLAIN;
                job_valid  = 1'b1;
                if (item.text_end)
                begin
                    job.kind = KIND_ERROR; job.err = ERR_ESC_CUT;
                    restart = 1'b1;
                end
                else
                begin
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: job.cp = c;
                        CH_B: job.cp = 21'h08;
                        CH_F: job.cp = 21'h0C;
                        CH_N: job.cp = 21'h0A;
                        CH_R: job.cp = 21'h0D;
                        CH_T: job.cp = 21'h09;
                        CH_U:
                        begin
                            job_valid  = 1'b0;
                            phase_next = PH_HEX1;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                        default:
                        begin
                            job.kind = KIND_ERROR; job.err = ERR_BAD_ESC;
                            restart = 1'b1;
                        end
                    endcase
                end
            end
            PH_WANT_BS:
            begin
                if (item.text_end || c != CH_BSL)
                begin
                    job_valid = 1'b1; job.kind = KIND_ERROR; job.err = ERR_HIGH_ALONE;
                    restart = 1'b1;
                end
                else
                    phase_next = PH_WANT_U;
            end
            PH_WANT_U:
            begin
                if (item.text_end || c != CH_U)
                begin
                    job_valid = 1'b1; job.kind = KIND_ERROR; job.err = ERR_HIGH_ALONE;
                    restart = 1'b1;
                end
                else
                begin
                    phase_next = PH_HEX2;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                if (item.text_end)
                begin
                    job_valid = 1'b1; job.kind = KIND_ERROR; job.err = ERR_HEX_CUT;
                    restart = 1'b1;
                end
                else if (!hex_ok)
                begin
                    job_valid = 1'b1; job.kind = KIND_ERROR; job.err = ERR_BAD_HEX;
                    restart = 1'b1;
                end
                else if (cnt_reg != 2'd3)
                begin
                    acc_next = u[11:0];
                    cnt_next = cnt_reg + 2'd1;
                end
                else
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    if (phase_reg == PH_HEX1)
                    begin
                        if (u inside {[16'hD800:16'hDBFF]})
                        begin
                            high_next  = u[9:0];
                            phase_next = PH_WANT_BS;
                        end
                        else if (u inside {[16'hDC00:16'hDFFF]})
                        begin
                            job_valid = 1'b1; job.kind = KIND_ERROR; job.err = ERR_LONE_LOW;
                            restart = 1'b1;
                        end
                        else if (u == 16'h0000)
                        begin
                            job_valid = 1'b1; job.kind = KIND_ERROR; job.err = ERR_NUL;
                            restart = 1'b1;
                        end
                        else
                        begin
                            job_valid  = 1'b1;
                            job.cp     = {5'd0, u};
                            phase_next = PH_PLAIN;
                        end
                    end
                    else
                    begin
                        job_valid = 1'b1;
                        restart   = 1'b1;
                        if (u inside {[16'hDC00:16'hDFFF]})
                            job.cp = 21'h10000 + {1'b0, high_reg, u[9:0]};
                        else
                        begin
                            job.kind = KIND_ERROR; job.err = ERR_HIGH_NO_LOW;
                        end
                    end
                end
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase

        // Back to a fresh string after close, error, joined pair or lost phase
        if (restart)
        begin
            phase_next = PH_PLAIN;
            acc_next   = '0;
            cnt_next   = '0;
            high_next  = '0;
        end
        if (job.kind != KIND_DATA)
            job.cp = '0;
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            high_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            high_reg  <= high_next;
        end
    end

endmodule

// ===== sv/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Short job queue between parser and encoder, so each side stalls on its own.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  jsu_pkg::job_t  wr_job,
    input  logic           rd,
    output jsu_pkg::job_t  head,
    output logic           q_empty,
    output logic           q_full
);
    import jsu_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_ONE   = PW'(1);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);

    job_t           slots [DEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;

    assign head    = slots[rp_reg];
    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == FULL_CNT);

    // Write a job at the tail
    always_ff @(posedge clk)
    begin
        if (wr)
            slots[wp_reg] <= wr_job;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == LAST_SLOT) ? '0 : wp_reg + PTR_ONE;
            if (rd)
                rp_reg <= (rp_reg == LAST_SLOT) ? '0 : rp_reg + PTR_ONE;
            if (wr && !rd)
                cnt_reg <= cnt_reg + CNT_ONE;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - CNT_ONE;
        end
    end

endmodule

// ===== sv/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Encoder: expands the job at the queue head into one to four UTF-8 bytes,
// or one close or error result, into a result register one per cycle if free.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  jsu_pkg::job_t   head,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output jsu_pkg::out_t   result
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    out_t       res_reg, res_next;

    logic       slot_free;
    logic       advance;
    logic [1:0] last_idx;
    logic       is_last;
    logic [1:0] shift;
    logic [5:0] six;
    logic [7:0] byte_val;

    assign slot_free = !ov_reg || pop;
    assign advance   = !q_empty && slot_free;

    // Byte count of the head job, as index of its final byte
    always_comb
    begin
        if (head.kind != KIND_DATA || head.cp < 21'h80)
            last_idx = 2'd0;
        else if (head.cp < 21'h800)
            last_idx = 2'd1;
        else if (head.cp < 21'h10000)
            last_idx = 2'd2;
        else
            last_idx = 2'd3;
    end

    assign is_last = (idx_reg == last_idx);
    assign shift   = last_idx - idx_reg;

    // Pick the lead or continuation byte
    always_comb
    begin
        case (shift)
            2'd0:    six = head.cp[5:0];
            2'd1:    six = head.cp[11:6];
            2'd2:    six = head.cp[17:12];
            default: six = '0;
        endcase
        if (idx_reg != 2'd0)
            byte_val = {2'b10, six};
        else
        begin
            case (last_idx)
                2'd0:    byte_val = {1'b0, head.cp[6:0]};
                2'd1:    byte_val = {3'b110, head.cp[10:6]};
                2'd2:    byte_val = {4'b1110, head.cp[15:12]};
                default: byte_val = {5'b11110, head.cp[20:18]};
            endcase
        end
    end

    // Load the result register and step through the job's bytes
    always_comb
    begin
        q_pop    = advance && is_last;
        idx_next = idx_reg;
        ov_next  = ov_reg && !pop;
        res_next = res_reg;
        if (advance)
        begin
            ov_next             = 1'b1;
            idx_next            = is_last ? 2'd0 : idx_reg + 2'd1;
            res_next.kind       = head.kind;
            res_next.out_byte   = (head.kind == KIND_DATA) ? byte_val : 8'd0;
            res_next.error_code = head.err;
            res_next.last       = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign empty  = !ov_reg;
    assign result = res_reg;

endmodule

// ===== sv/json_string_unescaper.sv =====
// ----------------------------------------------------------------------------
// json_string_unescaper
// Decodes a JSON string body, one code point per request, into UTF-8 bytes,
// a close result at the quote, or an error result with its code.
//
//   channel   handshake            payload
//   request   push / full          item   (in_t:  char_code, text_end)
//   result    empty / pop          result (out_t: kind, out_byte,
//                                          error_code, last)
//
// A request enters whenever the job queue has room; escape and hex digit requests
// produce no job until the character is complete. The encoder drives one result
// per cycle while its result register is free or popped, so a character costs
// one result per UTF-8 byte, 1 to 4. Reset clears parser phase, queue pointers and
// the result valid flag. Either side may stall; QUEUE_DEPTH jobs absorb the difference.
// ----------------------------------------------------------------------------
module json_string_unescaper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  jsu_pkg::in_t    item,
    output logic            empty,
    input  logic            pop,
    output jsu_pkg::out_t   result
);
    import jsu_pkg::*;

    logic take;
    logic job_valid;
    job_t job;
    job_t head;
    logic q_empty;
    logic q_full;
    logic q_pop;

    assign full = q_full;
    assign take = push && !q_full;

    // Parse requests
    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .job_valid (job_valid),
        .job       (job)
    );

    // Buffer jobs
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (take && job_valid),
        .wr_job  (job),
        .rd      (q_pop),
        .head    (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    // Encode to bytes
    jsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // Close and error results are always the final one of their request
    a_single_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_DATA) |-> result.last)
        else $error("close or error result without last");

    // An error result carries a code, other kinds carry none
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.kind == KIND_ERROR) == (result.error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // A taken non-final byte is followed at once by the next byte of the same character
    a_seq_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !result.last) |=> (!empty && result.kind == KIND_DATA
            && result.out_byte[7:6] == 2'b10))
        else $error("multi-byte character broken");

    // A popped job always belongs to a non-empty queue
    a_pop_guard: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job queue read while empty");

endmodule
